// ===== rtl/battery_level_monitor_defines.svh =====
// Assertion macros used by the RTL file battery_level_monitor.sv.
`ifndef BATTERY_LEVEL_MONITOR_DEFINES_SVH
`define BATTERY_LEVEL_MONITOR_DEFINES_SVH

// Check cons in the same cycle whenever ante holds (outside reset).
`define BLM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds (outside reset).
`define BLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/blm_pkg.sv =====
package blm_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_EVAL   = 2'd1,
    OP_DETECT = 2'd2
  } opcode_t;

  localparam int AdcW   = 12;
  localparam int VoltW  = 10;
  localparam int LevelW = 3;
  localparam int CountW = 2;

  // Tracker slew limits
  localparam logic signed [AdcW:0] BIG_GAP    = 13'sd50;
  localparam logic signed [AdcW:0] SMALL_GAP  = 13'sd10;
  localparam logic [AdcW-1:0]      BIG_STEP   = 12'd50;
  localparam logic [AdcW-1:0]      SMALL_STEP = 12'd5;

  // Voltage = floor(adc * 13 / 100) + 3, floor done as multiply by
  // ceil(13 * 2^19 / 100) and shift right by 19 (exact for 12-bit adc)
  localparam int              VOLT_SHIFT = 19;
  localparam int              PROD_W     = 29;
  localparam logic [16:0]     VOLT_MUL   = 17'd68158;
  localparam logic [VoltW-1:0] VOLT_OFFSET = 10'd3;
  localparam logic [VoltW-1:0] VOLT_MAX    = 10'd535;

  // Chemistry codes
  localparam logic CHEM_LITHIUM = 1'b0;
  localparam logic CHEM_ZINC    = 1'b1;

  // Detect threshold: above it the cell is taken as lithium
  localparam logic [VoltW-1:0] DETECT_THRESH = 10'd67;

  localparam logic [LevelW-1:0] LEVEL_MAX = 3'd4;
  localparam logic [CountW-1:0] LOW_MAX   = 2'd3;

  // Grade a voltage 0..4 against the thresholds of the chemistry
  function automatic logic [LevelW-1:0] grade(input logic [VoltW-1:0] v, input logic zinc);
    logic [LevelW-1:0] lvl;
    if (zinc == CHEM_LITHIUM) begin
      if (v > 10'd75)      lvl = 3'd4;
      else if (v > 10'd73) lvl = 3'd3;
      else if (v > 10'd69) lvl = 3'd2;
      else if (v > 10'd67) lvl = 3'd1;
      else                 lvl = 3'd0;
    end else begin
      if (v > 10'd58)      lvl = 3'd4;
      else if (v > 10'd54) lvl = 3'd3;
      else if (v > 10'd50) lvl = 3'd2;
      else if (v > 10'd47) lvl = 3'd1;
      else                 lvl = 3'd0;
    end
    return lvl;
  endfunction

endpackage

// ===== rtl/battery_level_monitor.sv =====
// An input transfer is held in the input register, then enters the state/result registers.
// Throughput: one item per cycle unless out_ready stalls; then at most one more item is held.
// The whole update (tracker step, one 12x17 multiply plus grading) is combinational.
// Reset (rst, synchronous, active high) clears all state, auto-switch and both valid flags.
`include "battery_level_monitor_defines.svh"

module battery_level_monitor (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic                           cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [blm_pkg::AdcW-1:0]       adc_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [blm_pkg::VoltW-1:0]      voltage_tenths,
  output logic [blm_pkg::LevelW-1:0]     battery_level,
  output logic                           chemistry,
  output logic                           low_protect
);

  // Configuration
  logic auto_switch_enable;

  // Input register
  logic                      in_valid_q;
  logic [1:0]                op_q;
  logic [blm_pkg::AdcW-1:0]  sample_q;

  // Block state; the visible part doubles as the result register
  logic [blm_pkg::AdcW-1:0]   tracked_adc, tracked_adc_next;
  logic [blm_pkg::VoltW-1:0]  voltage_reg, voltage_reg_next;
  logic [blm_pkg::LevelW-1:0] level_reg, level_reg_next;
  logic                       chemistry_reg, chemistry_reg_next;
  logic [blm_pkg::CountW-1:0] low_count, low_count_next;
  logic                       protect_flag, protect_flag_next;

  logic advance;
  logic signed [blm_pkg::AdcW:0] gap;
  logic [blm_pkg::PROD_W-1:0]    prod;
  logic [blm_pkg::VoltW-1:0]     volt_calc;
  logic [blm_pkg::LevelW-1:0]    level_calc;

  // Move the held item into the result slot when it is free or being emptied
  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;

  // Tracker gap and voltage scaling
  assign gap  = $signed({1'b0, sample_q}) - $signed({1'b0, tracked_adc});
  assign prod = {{(blm_pkg::PROD_W - blm_pkg::AdcW){1'b0}}, tracked_adc}
              * {{(blm_pkg::PROD_W - 17){1'b0}}, blm_pkg::VOLT_MUL};
  assign volt_calc  = prod[blm_pkg::VOLT_SHIFT +: blm_pkg::VoltW] + blm_pkg::VOLT_OFFSET;
  assign level_calc = blm_pkg::grade(volt_calc, chemistry_reg);

  // Per-item state update
  always_comb begin
    tracked_adc_next   = tracked_adc;
    voltage_reg_next   = voltage_reg;
    level_reg_next     = level_reg;
    chemistry_reg_next = chemistry_reg;
    low_count_next     = low_count;
    protect_flag_next  = protect_flag;
    case (op_q)
      blm_pkg::OP_SAMPLE: begin
        if (gap > blm_pkg::BIG_GAP) begin
          tracked_adc_next = tracked_adc + blm_pkg::BIG_STEP;
        end else if (gap > blm_pkg::SMALL_GAP) begin
          tracked_adc_next = tracked_adc + blm_pkg::SMALL_STEP;
        end else if (gap < -blm_pkg::BIG_GAP) begin
          tracked_adc_next = tracked_adc - blm_pkg::BIG_STEP;
        end else if (gap < -blm_pkg::SMALL_GAP) begin
          tracked_adc_next = tracked_adc - blm_pkg::SMALL_STEP;
        end
      end
      blm_pkg::OP_EVAL: begin
        voltage_reg_next = volt_calc;
        level_reg_next   = level_calc;
        if (level_calc == '0) begin
          if (low_count != blm_pkg::LOW_MAX) low_count_next = low_count + 2'd1;
          else                               protect_flag_next = 1'b1;
        end else begin
          if (low_count != '0) low_count_next = low_count - 2'd1;
          else                 protect_flag_next = 1'b0;
        end
      end
      blm_pkg::OP_DETECT: begin
        if (auto_switch_enable) begin
          chemistry_reg_next = (voltage_reg > blm_pkg::DETECT_THRESH) ?
                               blm_pkg::CHEM_LITHIUM : blm_pkg::CHEM_ZINC;
        end else begin
          chemistry_reg_next = blm_pkg::CHEM_LITHIUM;
        end
      end
      default: begin
        // unused code: hold state, still return a result
      end
    endcase
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_switch_enable <= 1'b0;
    end else if (cfg_write) begin
      auto_switch_enable <= cfg_data;
    end
  end

  // Capture input transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= opcode;
      sample_q <= adc_sample;
    end
  end

  // Advance state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      tracked_adc   <= '0;
      voltage_reg   <= '0;
      level_reg     <= '0;
      chemistry_reg <= blm_pkg::CHEM_LITHIUM;
      low_count     <= '0;
      protect_flag  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid     <= 1'b1;
        tracked_adc   <= tracked_adc_next;
        voltage_reg   <= voltage_reg_next;
        level_reg     <= level_reg_next;
        chemistry_reg <= chemistry_reg_next;
        low_count     <= low_count_next;
        protect_flag  <= protect_flag_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign voltage_tenths = voltage_reg;
  assign battery_level  = level_reg;
  assign chemistry      = chemistry_reg;
  assign low_protect    = protect_flag;

  // Checks
  `BLM_ASSERT_NEXT(a_state_holds, !advance,
                   $stable(tracked_adc) && $stable(low_count) && $stable(voltage_reg),
                   "state changed without an item")
  `BLM_ASSERT_SAME(a_protect_after_full_count, $rose(protect_flag),
                   $past(low_count) == blm_pkg::LOW_MAX,
                   "protect set before counter saturated")
  `BLM_ASSERT_SAME(a_result_range, out_valid,
                   (voltage_reg <= blm_pkg::VOLT_MAX) && (level_reg <= blm_pkg::LEVEL_MAX),
                   "result out of range")
  `BLM_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready,
                   "input stalled with empty result slot")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Opcode with no action; the block must leave its state alone
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 430;
  localparam int NUM_PHASES    = 4;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [blm_pkg::VoltW-1:0]  volt;
    logic [blm_pkg::LevelW-1:0] level;
    logic                       chem;
    logic                       prot;
  } battery_reading_t;

  typedef struct packed {
    logic [1:0]                op;
    logic [blm_pkg::AdcW-1:0]  sample;
    logic                      typed;
    battery_reading_t          want;
  } dir_row_t;

  localparam battery_reading_t NO_READING = '0;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic                       cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [1:0]                 opcode;
  logic [blm_pkg::AdcW-1:0]   adc_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic [blm_pkg::VoltW-1:0]  voltage_tenths;
  logic [blm_pkg::LevelW-1:0] battery_level;
  logic                       chemistry;
  logic                       low_protect;

  // Monitor state as the block should hold it
  logic [blm_pkg::AdcW-1:0]   trk;
  logic [blm_pkg::VoltW-1:0]  volt;
  logic [blm_pkg::LevelW-1:0] lvl;
  logic                       chem;
  logic [blm_pkg::CountW-1:0] low_cnt;
  logic                       prot;
  logic                       auto_sw;

  battery_reading_t  pending_readings[$];
  dir_row_t          dir_rows[15];
  int                mismatches;
  int                idle_cycles;
  bit                calm;
  bit                hold_req;

  battery_level_monitor u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .adc_sample     (adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .voltage_tenths (voltage_tenths),
    .battery_level  (battery_level),
    .chemistry      (chemistry),
    .low_protect    (low_protect)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Grade a voltage against the lithium or zinc-manganese thresholds
  function automatic logic [blm_pkg::LevelW-1:0] level_for(input logic [blm_pkg::VoltW-1:0] v,
                                                           input logic c);
    if (c == blm_pkg::CHEM_LITHIUM) begin
      if (v > 75) return 3'd4;
      if (v > 73) return 3'd3;
      if (v > 69) return 3'd2;
      if (v > 67) return 3'd1;
      return 3'd0;
    end
    if (v > 58) return 3'd4;
    if (v > 54) return 3'd3;
    if (v > 50) return 3'd2;
    if (v > 47) return 3'd1;
    return 3'd0;
  endfunction

  // Advance the monitor state by one item and report the registers after it
  task automatic apply_item(input logic [1:0] op, input logic [blm_pkg::AdcW-1:0] s,
                            output battery_reading_t r);
    int gap;
    gap = int'(s) - int'(trk);
    case (op)
      blm_pkg::OP_SAMPLE: begin
        if (gap > 50)       trk = trk + blm_pkg::BIG_STEP;
        else if (gap > 10)  trk = trk + blm_pkg::SMALL_STEP;
        else if (gap < -50) trk = trk - blm_pkg::BIG_STEP;
        else if (gap < -10) trk = trk - blm_pkg::SMALL_STEP;
      end
      blm_pkg::OP_EVAL: begin
        volt = blm_pkg::VoltW'((int'(trk) * 13) / 100 + 3);
        lvl  = level_for(volt, chem);
        // saturating low counter drives the protect flag
        if (lvl == 0) begin
          if (low_cnt < blm_pkg::LOW_MAX) low_cnt = low_cnt + 1'b1;
          else prot = 1'b1;
        end else begin
          if (low_cnt > 0) low_cnt = low_cnt - 1'b1;
          else prot = 1'b0;
        end
      end
      blm_pkg::OP_DETECT: begin
        chem = (auto_sw && volt <= blm_pkg::DETECT_THRESH) ?
               blm_pkg::CHEM_ZINC : blm_pkg::CHEM_LITHIUM;
      end
      default: ;
    endcase
    r = '{volt, lvl, chem, prot};
  endtask

  // Offer one item, wait for its transfer, then queue the reading it should give
  task automatic send_item(input logic [1:0] op, input logic [blm_pkg::AdcW-1:0] s,
                           input logic typed, input battery_reading_t want);
    int gap;
    battery_reading_t predicted;
    gap = (!calm && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 17)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    adc_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(op, s, predicted);
    pending_readings.push_back(typed ? want : predicted);
  endtask

  // Drop valid and let every outstanding reading come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_auto(input logic v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    auto_sw = v;
  endtask

  // Settle-and-grade sequences, with sweeps, grading runs and noise
  task automatic run_random(input int n_items);
    int sent;
    int kind;
    int reps;
    int k;
    logic [blm_pkg::AdcW-1:0] target;
    logic [1:0] op;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // settle near a target, biased to the grading thresholds, then grade
        if ($urandom_range(0, 1) == 1) target = blm_pkg::AdcW'($urandom_range(300, 620));
        else target = blm_pkg::AdcW'($urandom_range(0, 4095));
        reps = $urandom_range(3, 30);
        for (k = 0; k < reps; k++) begin
          send_item(blm_pkg::OP_SAMPLE, target ^ blm_pkg::AdcW'($urandom_range(0, 15)),
                    1'b0, NO_READING);
        end
        sent += reps;
        reps = $urandom_range(1, 3);
        for (k = 0; k < reps; k++) begin
          send_item(blm_pkg::OP_EVAL, blm_pkg::AdcW'($urandom), 1'b0, NO_READING);
        end
        sent += reps;
        if ($urandom_range(0, 1) == 1) begin
          send_item(blm_pkg::OP_DETECT, blm_pkg::AdcW'($urandom), 1'b0, NO_READING);
          send_item(blm_pkg::OP_EVAL, blm_pkg::AdcW'($urandom), 1'b0, NO_READING);
          sent += 2;
        end
      end else if (kind < 55) begin
        // sweep the tracker toward one end of its range
        target = ($urandom_range(0, 1) == 1) ? blm_pkg::AdcW'(4095) : blm_pkg::AdcW'(0);
        reps = $urandom_range(60, 90);
        for (k = 0; k < reps; k++) send_item(blm_pkg::OP_SAMPLE, target, 1'b0, NO_READING);
        send_item(blm_pkg::OP_EVAL, blm_pkg::AdcW'($urandom), 1'b0, NO_READING);
        send_item(blm_pkg::OP_DETECT, blm_pkg::AdcW'($urandom), 1'b0, NO_READING);
        sent += reps + 2;
      end else if (kind < 80) begin
        // walk the low counter and chemistry without moving the tracker
        reps = $urandom_range(1, 6);
        for (k = 0; k < reps; k++) begin
          op = ($urandom_range(0, 2) == 0) ? 2'(blm_pkg::OP_DETECT) : 2'(blm_pkg::OP_EVAL);
          send_item(op, blm_pkg::AdcW'($urandom), 1'b0, NO_READING);
        end
        sent += reps;
      end else begin
        reps = $urandom_range(1, 8);
        for (k = 0; k < reps; k++) begin
          op = 2'($urandom_range(0, 3));
          send_item(op, blm_pkg::AdcW'($urandom), 1'b0, NO_READING);
          sent++;
        end
      end
    end
  endtask

  task automatic check_reading(input battery_reading_t want);
    if (voltage_tenths !== want.volt) begin
      $error("voltage_tenths: expected %0d, got %0d", want.volt, voltage_tenths);
      mismatches++;
    end
    if (battery_level !== want.level) begin
      $error("battery_level: expected %0d, got %0d", want.level, battery_level);
      mismatches++;
    end
    if (chemistry !== want.chem) begin
      $error("chemistry: expected %0d, got %0d", want.chem, chemistry);
      mismatches++;
    end
    if (low_protect !== want.prot) begin
      $error("low_protect: expected %0d, got %0d", want.prot, low_protect);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest pending reading
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("result transfer with no reading pending: voltage_tenths %0d", voltage_tenths);
        mismatches++;
      end else begin
        check_reading(pending_readings.pop_front());
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold off long enough for the block to fill and stall its input
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    // after reset, protect set-up, slew steps and holds, detect, unused opcode
    dir_rows = '{
      '{OP_SPARE,           12'd0,    1'b1, '{10'd0, 3'd0, blm_pkg::CHEM_LITHIUM, 1'b0}},
      '{blm_pkg::OP_EVAL,   12'd0,    1'b1, '{10'd3, 3'd0, blm_pkg::CHEM_LITHIUM, 1'b0}},
      '{blm_pkg::OP_EVAL,   12'd4095, 1'b1, '{10'd3, 3'd0, blm_pkg::CHEM_LITHIUM, 1'b0}},
      '{blm_pkg::OP_EVAL,   12'd0,    1'b1, '{10'd3, 3'd0, blm_pkg::CHEM_LITHIUM, 1'b0}},
      '{blm_pkg::OP_EVAL,   12'd0,    1'b1, '{10'd3, 3'd0, blm_pkg::CHEM_LITHIUM, 1'b1}},
      '{blm_pkg::OP_SAMPLE, 12'd4095, 1'b1, '{10'd3, 3'd0, blm_pkg::CHEM_LITHIUM, 1'b1}},
      '{blm_pkg::OP_SAMPLE, 12'd4095, 1'b0, NO_READING},
      '{blm_pkg::OP_SAMPLE, 12'd0,    1'b0, NO_READING},
      '{blm_pkg::OP_SAMPLE, 12'd61,   1'b0, NO_READING},
      '{blm_pkg::OP_SAMPLE, 12'd65,   1'b0, NO_READING},
      '{blm_pkg::OP_SAMPLE, 12'd44,   1'b0, NO_READING},
      '{blm_pkg::OP_SAMPLE, 12'd39,   1'b0, NO_READING},
      '{blm_pkg::OP_EVAL,   12'd0,    1'b0, NO_READING},
      '{blm_pkg::OP_DETECT, 12'd0,    1'b0, NO_READING},
      '{OP_SPARE,           12'd4095, 1'b0, NO_READING}
    };
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= 1'b0;
    in_valid   <= 1'b0;
    opcode     <= blm_pkg::OP_SAMPLE;
    adc_sample <= '0;
    mismatches = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    trk        = '0;
    volt       = '0;
    lvl        = '0;
    chem       = blm_pkg::CHEM_LITHIUM;
    low_cnt    = '0;
    prot       = 1'b0;
    auto_sw    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    // random phases, auto-switch off only in the second; the last has no idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_auto(ph != 1);
      if (ph == 0) hold_req = 1'b1;
      calm = (ph == NUM_PHASES - 1);
      run_random(PHASE_ITEMS);
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
